// ----- rtl/integer_text_parser_auto_base_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the integer text parser
// Shared clocking and reset for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TEXT_PARSER_AUTO_BASE_DEFINES_SVH
`define INTEGER_TEXT_PARSER_AUTO_BASE_DEFINES_SVH

// Plain check, sampled on clk_i, off while rst_ni is low.
`define ITP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that only applies while a result is offered.
`define ITP_ASSERT_OUT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (out_valid_i |-> (prop))) else $error(msg);

`endif

// ----- rtl/itp_pkg.sv -----
// ----------------------------------------------------------------------------
// itp_pkg
// Types, codes and constants shared by the integer text parser.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int VALUE_WIDTH = 64;   // clamp range of the result
  localparam int DIGIT_LIMIT = 1024; // digit limit when max_digits is zero
  localparam int VAL_W       = 64;   // result value field
  localparam int CNT_W       = 11;
  localparam int BASE_W      = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIGITS = 1'd1;

  localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
  localparam logic [BASE_W-1:0] BASE_2    = 5'd2;
  localparam logic [BASE_W-1:0] BASE_8    = 5'd8;
  localparam logic [BASE_W-1:0] BASE_10   = 5'd10;
  localparam logic [BASE_W-1:0] BASE_16   = 5'd16;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [VAL_W-1:0] SAT_MAX = {VAL_W{1'b1}} >> (65 - VALUE_WIDTH);
  localparam logic [VAL_W-1:0] SAT_MIN = ~SAT_MAX;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NAN  = 2'd1,
    ST_ZERO = 2'd2
  } itp_status_e;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_AUTO0  = 2'd1,
    PH_PFX1   = 2'd2,
    PH_DIGITS = 2'd3
  } itp_phase_e;

  // Byte class produced by the front end.
  typedef struct packed {
    logic [3:0] digit;
    logic       dig2;
    logic       dig8;
    logic       dig10;
    logic       dig16;
    logic       is_ws;
    logic       is_zero;
    logic       is_plus;
    logic       is_minus;
    logic       is_x;
    logic       is_b;
    logic       eoi;
  } itp_class_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [1:0]       status;
    logic [1:0]       pushback;
    logic             saturated;
  } itp_res_t;

endpackage

// ----- rtl/itp_if.sv -----
// ----------------------------------------------------------------------------
// itp_if
// Valid/ready channels for text bytes in and parsed results out.
// ----------------------------------------------------------------------------
interface itp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;

  modport source (output valid, output char_byte, output end_of_input, input ready);
  modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface itp_res_if;
  import itp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic [1:0]              status;
  logic [1:0]              pushback_count;
  logic                    saturated;

  modport source (output valid, output value, output status, output pushback_count,
                  output saturated, input ready);
  modport sink   (input valid, input value, input status, input pushback_count,
                  input saturated, output ready);
endinterface

// ----- rtl/itp_front.sv -----
// ----------------------------------------------------------------------------
// itp_front
// Classifies each incoming byte and pushes the class into the queue.
// ----------------------------------------------------------------------------
module itp_front (
  itp_char_if.sink          in_i,
  input  logic              q_full_i,
  output logic              push_o,
  output itp_pkg::itp_class_t cls_o
);
  import itp_pkg::*;

  logic [7:0] lc;
  logic [7:0] dsub;
  logic       is_dec;
  logic       is_hex;
  logic       live;

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  always_comb begin
    lc     = (in_i.char_byte >= CH_UA && in_i.char_byte <= CH_UZ) ?
             in_i.char_byte + 8'd32 : in_i.char_byte;
    is_dec = lc >= CH_0 && lc <= CH_9;
    is_hex = lc >= CH_A && lc <= CH_F;
    dsub   = is_dec ? lc - CH_0 : lc - CH_A + 8'd10;
    live   = !in_i.end_of_input;

    cls_o.digit    = dsub[3:0];
    cls_o.dig2     = live && is_dec && dsub < 8'd2;
    cls_o.dig8     = live && is_dec && dsub < 8'd8;
    cls_o.dig10    = live && is_dec;
    cls_o.dig16    = live && (is_dec || is_hex);
    cls_o.is_ws    = live && (in_i.char_byte == CH_SPACE ||
                     (in_i.char_byte >= CH_TAB && in_i.char_byte <= CH_CR));
    cls_o.is_zero  = live && in_i.char_byte == CH_0;
    cls_o.is_plus  = live && in_i.char_byte == CH_PLUS;
    cls_o.is_minus = live && in_i.char_byte == CH_MINUS;
    cls_o.is_x     = live && lc == CH_X;
    cls_o.is_b     = live && lc == CH_B;
    cls_o.eoi      = in_i.end_of_input;
  end

endmodule

// ----- rtl/itp_queue.sv -----
// ----------------------------------------------------------------------------
// itp_queue
// Two-entry queue of byte classes between front end and parser.
// ----------------------------------------------------------------------------
module itp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  itp_pkg::itp_class_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output itp_pkg::itp_class_t data_o
);
  import itp_pkg::*;

  itp_class_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/itp_back.sv -----
// ----------------------------------------------------------------------------
// itp_back
// Token parser: prefix handling, digit accumulation, clamp and result register.
// ----------------------------------------------------------------------------
module itp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [itp_pkg::BASE_W-1:0] base_mode_i,
  input  logic [itp_pkg::CNT_W-1:0]  max_digits_i,
  input  logic                       q_valid_i,
  input  itp_pkg::itp_class_t        cls_i,
  output logic                       pop_o,
  itp_res_if.source                  out_o
);
  import itp_pkg::*;

  localparam logic [VAL_W-1:0] NEG_LIM = SAT_MAX + 64'd1;

  itp_phase_e        ph_q, ph_d;
  logic [BASE_W-1:0] base_q, base_d;
  logic [VAL_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              neg_q, neg_d;
  logic              ovf_q, ovf_d;
  logic [1:0]        held_q, held_d;

  logic              out_v_q, out_v_d;
  itp_res_t          res_q, res;

  logic              emit, do_fin;
  logic [1:0]        fin_pb;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W:0]    cnt_inc;
  logic              dig_ok;
  logic [VAL_W+4:0]  mac;
  logic [VAL_W+4:0]  acc_w;
  logic [VAL_W+4:0]  dig_w;

  function automatic itp_res_t finish(logic [VAL_W-1:0] mag, logic neg, logic ovf,
                                      logic [1:0] pb);
    itp_res_t r;
    logic [VAL_W-1:0] m;
    m           = mag;
    r.saturated = ovf;
    if (neg) begin
      if (m > NEG_LIM) begin
        m           = NEG_LIM;
        r.saturated = 1'b1;
      end
      r.value = 64'd0 - m;
    end else begin
      if (m > SAT_MAX) begin
        m           = SAT_MAX;
        r.saturated = 1'b1;
      end
      r.value = m;
    end
    r.status   = ST_OK;
    r.pushback = pb;
    return r;
  endfunction

  // A byte is consumed when the result register is free or being drained.
  assign pop_o = q_valid_i && (!out_v_q || out_o.ready);

  assign lim     = (max_digits_i == '0) ? CNT_W'(DIGIT_LIMIT) : max_digits_i;
  assign cnt_inc = {1'b0, cnt_q} + (CNT_W+1)'(1);

  // Constant-base multiply-add as shifts; the top bits flag a 64-bit overflow.
  always_comb begin
    acc_w = {5'd0, acc_q};
    dig_w = {{(VAL_W+1){1'b0}}, cls_i.digit};
    case (base_q)
      BASE_2:  mac = (acc_w << 1) + dig_w;
      BASE_8:  mac = (acc_w << 3) + dig_w;
      BASE_16: mac = (acc_w << 4) + dig_w;
      default: mac = (acc_w << 3) + (acc_w << 1) + dig_w;
    endcase
    case (base_q)
      BASE_2:  dig_ok = cls_i.dig2;
      BASE_8:  dig_ok = cls_i.dig8;
      BASE_16: dig_ok = cls_i.dig16;
      default: dig_ok = cls_i.dig10;
    endcase
  end

  always_comb begin
    ph_d   = ph_q;
    base_d = base_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    ovf_d  = ovf_q;
    held_d = held_q;
    emit   = 1'b0;
    do_fin = 1'b0;
    fin_pb = 2'd0;
    res    = '{value: '0, status: ST_OK, pushback: 2'd0, saturated: 1'b0};

    unique case (ph_q)
      PH_SKIP: begin
        if (cls_i.eoi) begin
          emit       = 1'b1;
          res.status = ST_ZERO;
        end else if (!cls_i.is_ws) begin
          base_d = base_mode_i;
          if ((base_mode_i == BASE_AUTO && !cls_i.is_zero) || base_mode_i == BASE_10) begin
            // signed decimal start
            base_d = BASE_10;
            ph_d   = PH_DIGITS;
            if (cls_i.is_plus || cls_i.is_minus) begin
              neg_d = cls_i.is_minus;
            end else if (cls_i.dig10) begin
              acc_d = {{(VAL_W-4){1'b0}}, cls_i.digit};
              cnt_d = CNT_W'(1);
              if (lim == CNT_W'(1)) begin
                do_fin = 1'b1;
              end
            end else begin
              emit         = 1'b1;
              res.status   = ST_NAN;
              res.pushback = 2'd1;
            end
          end else if (base_mode_i == BASE_AUTO) begin
            ph_d = PH_AUTO0;
          end else if (base_mode_i == BASE_2 || base_mode_i == BASE_8 ||
                       base_mode_i == BASE_16) begin
            if (!cls_i.is_zero) begin
              emit       = 1'b1;
              res.status = ST_ZERO;
            end else if (base_mode_i == BASE_8) begin
              held_d = 2'd1;
              ph_d   = PH_DIGITS;
            end else begin
              ph_d = PH_PFX1;
            end
          end else begin
            emit         = 1'b1;
            res.status   = ST_NAN;
            res.pushback = 2'd1;
          end
        end
      end
      PH_AUTO0: begin
        if (cls_i.eoi) begin
          emit = 1'b1;  // lone zero
        end else if (cls_i.is_x || cls_i.is_b) begin
          base_d = cls_i.is_x ? BASE_16 : BASE_2;
          held_d = 2'd2;
          ph_d   = PH_DIGITS;
        end else begin
          ph_d = PH_DIGITS;
          if (cls_i.dig8) begin
            base_d = BASE_8;
            held_d = 2'd1;
            acc_d  = {{(VAL_W-4){1'b0}}, cls_i.digit};
            cnt_d  = CNT_W'(1);
            do_fin = lim == CNT_W'(1);
          end else begin
            // the leading zero counts as a decimal digit
            base_d = BASE_10;
            cnt_d  = CNT_W'(1);
            if (lim == CNT_W'(1)) begin
              do_fin = 1'b1;
              fin_pb = 2'd1;
            end else if (cls_i.dig10) begin
              acc_d  = {{(VAL_W-4){1'b0}}, cls_i.digit};
              cnt_d  = CNT_W'(2);
              do_fin = lim <= CNT_W'(2);
            end else begin
              do_fin = 1'b1;
              fin_pb = 2'd1;
            end
          end
        end
      end
      PH_PFX1: begin
        if (cls_i.eoi || !(base_q == BASE_2 ? cls_i.is_b : cls_i.is_x)) begin
          emit       = 1'b1;
          res.status = ST_ZERO;
        end else begin
          held_d = 2'd2;
          ph_d   = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        if (dig_ok) begin
          if (!ovf_q) begin
            if (mac[VAL_W+4:VAL_W] != '0) begin
              ovf_d = 1'b1;
              acc_d = '1;
            end else begin
              acc_d = mac[VAL_W-1:0];
            end
          end
          cnt_d  = cnt_inc[CNT_W-1:0];
          do_fin = cnt_inc >= {1'b0, lim};
        end else if (cnt_q == '0) begin
          emit         = 1'b1;
          res.status   = ST_NAN;
          res.pushback = held_q + {1'b0, !cls_i.eoi};
        end else begin
          do_fin = 1'b1;
          fin_pb = {1'b0, !cls_i.eoi};
        end
      end
      default: ;
    endcase

    if (do_fin) begin
      emit = 1'b1;
      res  = finish(acc_d, neg_d, ovf_d, fin_pb);
    end
    if (emit) begin
      ph_d   = PH_SKIP;
      base_d = '0;
      acc_d  = '0;
      cnt_d  = '0;
      neg_d  = 1'b0;
      ovf_d  = 1'b0;
      held_d = 2'd0;
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (out_v_q && out_o.ready) begin
      out_v_d = 1'b0;
    end
    if (pop_o && emit) begin
      out_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_SKIP;
      base_q  <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      held_q  <= 2'd0;
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      if (pop_o) begin
        ph_q   <= ph_d;
        base_q <= base_d;
        acc_q  <= acc_d;
        cnt_q  <= cnt_d;
        neg_q  <= neg_d;
        ovf_q  <= ovf_d;
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      res_q <= res;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.value          = res_q.value;
  assign out_o.status         = res_q.status;
  assign out_o.pushback_count = res_q.pushback;
  assign out_o.saturated      = res_q.saturated;

endmodule

// ----- rtl/integer_text_parser_auto_base.sv -----
// ----------------------------------------------------------------------------
// integer_text_parser_auto_base
// Byte-stream integer token parser with prefix-based base detection.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one text byte per transfer (char_byte, end_of_input).
//   out_o carries one result per finished token: value, status, pushback_count
//   and saturated. pushback_count says how many of the latest bytes belong to
//   the next token; the source presents them again.
//   Config: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 base_mode, 1 max_digits). Write only while the parser is idle.
// Timing:
//   One byte per cycle sustained while out_o accepts results. A result is
//   registered: the byte that ends the token lands in the class queue at its
//   transfer, and the parser loads the output register when it pops that
//   byte. The rate is set by the parser's combinational multiply-add.
// Reset:
//   Parser back to whitespace skipping, queue and output register empty,
//   base_mode auto, max_digits 0 (limit 1024).
// Stall:
//   While out_o is stalled the result holds; the parser stops and the
//   two-entry queue absorbs bytes until full, then in_i.ready drops.
// ----------------------------------------------------------------------------
module integer_text_parser_auto_base (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [itp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [itp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  itp_char_if.sink                       in_i,
  itp_res_if.source                      out_o
);
  import itp_pkg::*;

  logic [BASE_W-1:0] base_mode_q;
  logic [CNT_W-1:0]  max_digits_q;

  logic       push, q_full, q_valid, pop;
  itp_class_t cls_in, cls_out;

  // Configuration registers, read live by the parser.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_mode_q  <= '0;
      max_digits_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BASE_MODE:  base_mode_q  <= cfg_wdata_i[BASE_W-1:0];
        CFG_MAX_DIGITS: max_digits_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: classify the byte at transfer time.
  itp_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cls_o    (cls_in)
  );

  // Decoupling queue.
  itp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (cls_out)
  );

  // Back end: parser and result register.
  itp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .base_mode_i  (base_mode_q),
    .max_digits_i (max_digits_q),
    .q_valid_i    (q_valid),
    .cls_i        (cls_out),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

// ----- rtl/itp_checker.sv -----
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks on the parser results, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_text_parser_auto_base_defines.svh"

module itp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [itp_pkg::VAL_W-1:0]     out_value_i,
  input logic [1:0]                    out_status_i,
  input logic [1:0]                    out_pushback_i,
  input logic                          out_saturated_i
);
  import itp_pkg::*;

  `ITP_ASSERT(a_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) && $stable(out_status_i), "result changed while stalled")
  `ITP_ASSERT_OUT(a_fail_zero, out_status_i == ST_OK || (out_value_i == '0 && !out_saturated_i), "failed token carries a value")
  `ITP_ASSERT_OUT(a_sat_limit, !out_saturated_i || out_value_i == SAT_MAX || out_value_i == SAT_MIN, "saturated value not at a limit")
  `ITP_ASSERT_OUT(a_zero_pb, out_status_i != ST_ZERO || out_pushback_i == 2'd0, "silent zero with pushback")

endmodule

bind integer_text_parser_auto_base itp_checker u_itp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_value_i     (out_o.value),
  .out_status_i    (out_o.status),
  .out_pushback_i  (out_o.pushback_count),
  .out_saturated_i (out_o.saturated)
);

// ----- test/integer_text_parser_auto_base_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_text_parser_auto_base_tb
// Byte-stream stimulus for the integer token parser. A cycle-free model in the
// bench predicts every token result; a monitor compares each result transfer
// field by field in order. Directed tokens cover prefixes, signs, whitespace,
// clamping and digit limits; random token streams follow under many register
// settings, with random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
module integer_text_parser_auto_base_tb;
  import itp_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  itp_char_if char_ch ();
  itp_res_if  res_ch ();

  integer_text_parser_auto_base dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (char_ch),
    .out_o       (res_ch)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // --------------------------------------------------------------------------
  // Token model: register copies and per-token state
  // --------------------------------------------------------------------------
  logic [BASE_W-1:0] cur_base_mode;
  logic [CNT_W-1:0]  cur_max_digits;

  itp_phase_e        tok_phase;
  logic [BASE_W-1:0] tok_base;
  logic [63:0]       tok_mag;     // exact magnitude, pinned to all ones on overflow
  int                tok_ndig;
  bit                tok_neg;
  bit                tok_ovf;
  logic [1:0]        tok_held;    // prefix bytes seen so far

  itp_res_t expected_q[$];        // results still owed by the parser

  // Bench controls and statistics
  bit in_idle_en;
  bit out_idle_en;
  int hold_req;                   // cycles of output stall requested by a test
  int n_errors;
  int n_bytes;
  int n_ok, n_nan, n_zero, n_sat;
  int n_cfg_writes;

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Digit value of c in base, or -1 when c is not a digit there
  function automatic int digit_value(logic [7:0] c, logic [BASE_W-1:0] base);
    logic [7:0] lc;
    int d;
    lc = to_lower(c);
    d = -1;
    if (lc >= CH_0 && lc <= CH_9) d = lc - CH_0;
    else if (lc >= CH_A && lc <= CH_F) d = lc - CH_A + 10;
    if (d >= int'(base)) d = -1;
    return d;
  endfunction

  function automatic int digit_limit();
    return (cur_max_digits == 0) ? DIGIT_LIMIT : int'(cur_max_digits);
  endfunction

  function automatic void clear_token();
    tok_phase = PH_SKIP;
    tok_base  = BASE_AUTO;
    tok_mag   = '0;
    tok_ndig  = 0;
    tok_neg   = 1'b0;
    tok_ovf   = 1'b0;
    tok_held  = 2'd0;
  endfunction

  function automatic void post_result(logic [63:0] v, itp_status_e st, logic [1:0] pb,
                                      logic sat);
    itp_res_t r;
    r.value     = v;
    r.status    = st;
    r.pushback  = pb;
    r.saturated = sat;
    expected_q.push_back(r);
    clear_token();
  endfunction

  // Token complete with digits: clamp to the signed result range
  function automatic void close_number(logic [1:0] pb);
    logic [63:0] mag;
    logic sat;
    mag = tok_mag;
    sat = tok_ovf;
    if (tok_neg) begin
      if (mag > SAT_MAX + 64'd1) begin
        mag = SAT_MAX + 64'd1;
        sat = 1'b1;
      end
      post_result(64'd0 - mag, ST_OK, pb, sat);
    end else begin
      if (mag > SAT_MAX) begin
        mag = SAT_MAX;
        sat = 1'b1;
      end
      post_result(mag, ST_OK, pb, sat);
    end
  endfunction

  function automatic void take_digit(int d);
    logic [63:0] b, dd;
    b  = 64'(tok_base);
    dd = 64'(d);
    if (!tok_ovf && b != 0) begin
      if (tok_mag > ({64{1'b1}} - dd) / b) begin
        tok_ovf = 1'b1;
        tok_mag = {64{1'b1}};
      end else begin
        tok_mag = tok_mag * b + dd;
      end
    end
    tok_ndig++;
    if (tok_ndig >= digit_limit()) close_number(2'd0);
  endfunction

  function automatic void digit_byte(logic [7:0] c, bit eoi);
    int d;
    logic [1:0] extra;
    d = eoi ? -1 : digit_value(c, tok_base);
    extra = eoi ? 2'd0 : 2'd1;
    if (d >= 0) take_digit(d);
    else if (tok_ndig == 0) post_result('0, ST_NAN, tok_held + extra, 1'b0);
    else close_number(extra);
  endfunction

  function automatic void start_decimal(logic [7:0] c);
    tok_base  = BASE_10;
    tok_phase = PH_DIGITS;
    if (c == CH_PLUS || c == CH_MINUS) tok_neg = (c == CH_MINUS);
    else if (c >= CH_0 && c <= CH_9) take_digit(c - CH_0);
    else post_result('0, ST_NAN, 2'd1, 1'b0);
  endfunction

  // Advance the token model by one accepted byte
  function automatic void predict_byte(logic [7:0] c, bit eoi);
    logic [7:0] lc;
    lc = to_lower(c);
    case (tok_phase)
      PH_AUTO0: begin
        if (eoi) begin
          post_result('0, ST_OK, 2'd0, 1'b0);      // lone zero
        end else if (lc == CH_X || lc == CH_B) begin
          tok_base  = (lc == CH_X) ? BASE_16 : BASE_2;
          tok_held  = 2'd2;
          tok_phase = PH_DIGITS;
        end else begin
          tok_phase = PH_DIGITS;
          if (c >= CH_0 && c <= CH_7) begin
            tok_base = BASE_8;
            tok_held = 2'd1;
            take_digit(c - CH_0);
          end else begin
            // the leading zero counts as a decimal digit
            tok_base = BASE_10;
            tok_ndig = 1;
            if (tok_ndig >= digit_limit()) close_number(2'd1);
            else digit_byte(c, 1'b0);
          end
        end
      end
      PH_PFX1: begin
        if (eoi || lc != ((tok_base == BASE_2) ? CH_B : CH_X)) begin
          post_result('0, ST_ZERO, 2'd0, 1'b0);
        end else begin
          tok_held  = 2'd2;
          tok_phase = PH_DIGITS;
        end
      end
      PH_DIGITS: digit_byte(c, eoi);
      default: begin
        if (eoi) begin
          post_result('0, ST_ZERO, 2'd0, 1'b0);
        end else if (!is_space(c)) begin
          tok_base = cur_base_mode;          // base latched at the first byte
          if (tok_base == BASE_AUTO) begin
            if (c == CH_0) tok_phase = PH_AUTO0;
            else start_decimal(c);
          end else if (tok_base == BASE_10) begin
            start_decimal(c);
          end else if (tok_base == BASE_2 || tok_base == BASE_8 || tok_base == BASE_16) begin
            if (c != CH_0) begin
              post_result('0, ST_ZERO, 2'd0, 1'b0);
            end else if (tok_base == BASE_8) begin
              tok_held  = 2'd1;
              tok_phase = PH_DIGITS;
            end else begin
              tok_phase = PH_PFX1;
            end
          end else begin
            post_result('0, ST_NAN, 2'd1, 1'b0);   // invalid base_mode
          end
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Idle length: mostly short, now and then long
  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 30);
  endfunction

  // One byte transfer; valid stays high afterwards so back-to-back bytes
  // never see a low pulse.
  task automatic send_byte(input logic [7:0] c, input bit eoi);
    int gap;
    gap = (in_idle_en && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      char_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    char_ch.valid        = 1'b1;
    char_ch.char_byte    = c;
    char_ch.end_of_input = eoi;
    do @(posedge clk_i); while (!char_ch.ready);
    predict_byte(c, eoi);
    n_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // char_byte is don't-care with end_of_input, so it gets random bits
  task automatic send_end();
    send_byte(8'($urandom), 1'b1);
  endtask

  // Close any open token, stop offering, and wait for the parser to go quiet
  task automatic settle_parser();
    if (tok_phase != PH_SKIP) send_end();
    @(negedge clk_i);
    char_ch.valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_BASE_MODE) cur_base_mode = data[BASE_W-1:0];
    else cur_max_digits = data;
    n_cfg_writes++;
  endtask

  task automatic configure(input logic [BASE_W-1:0] base, input logic [CNT_W-1:0] maxd);
    settle_parser();
    write_reg(CFG_BASE_MODE, CFG_DATA_W'(base));
    write_reg(CFG_MAX_DIGITS, maxd);
  endtask

  function automatic logic [7:0] ws_char();
    return ($urandom_range(0, 2) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
  endfunction

  // Letters come out in either case at random
  function automatic logic [7:0] mix_case(logic [7:0] c);
    return $urandom_range(0, 1) ? c - 8'd32 : c;
  endfunction

  function automatic logic [7:0] digit_char(int d);
    return (d < 10) ? CH_0 + 8'(d) : mix_case(CH_A + 8'(d - 10));
  endfunction

  function automatic int digit_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 6);
    if (r < 96) return $urandom_range(7, 24);
    return $urandom_range(25, 70);       // enough to overflow even in binary
  endfunction

  // One token with random content: mostly well formed for the current base,
  // some with no digits, some plain noise.
  task automatic send_random_token();
    logic [8:0] seq[$];
    logic [BASE_W-1:0] b;
    int r, nd, t;
    repeat ($urandom_range(0, 2)) seq.push_back({1'b0, ws_char()});
    r = $urandom_range(0, 99);
    if (r < 12) begin
      repeat ($urandom_range(1, 4))
        seq.push_back({1'($urandom_range(0, 7) == 0), 8'($urandom)});
    end else begin
      b = cur_base_mode;
      if (b == BASE_AUTO) begin
        case ($urandom_range(0, 3))
          0:       b = BASE_2;
          1:       b = BASE_8;
          2:       b = BASE_10;
          default: b = BASE_16;
        endcase
      end
      nd = (r < 22) ? 0 : digit_len();
      case (b)
        BASE_2: begin
          seq.push_back({1'b0, CH_0});
          seq.push_back({1'b0, mix_case(CH_B)});
        end
        BASE_8: seq.push_back({1'b0, CH_0});
        BASE_16: begin
          seq.push_back({1'b0, CH_0});
          seq.push_back({1'b0, mix_case(CH_X)});
        end
        default: begin
          // decimal, also used for invalid modes
          t = $urandom_range(0, 5);
          if (t == 0) seq.push_back({1'b0, CH_PLUS});
          else if (t == 1) seq.push_back({1'b0, CH_MINUS});
          b = BASE_10;
        end
      endcase
      for (int i = 0; i < nd; i++) seq.push_back({1'b0, digit_char($urandom_range(0, b - 1))});
      t = $urandom_range(0, 9);
      if (t < 5) seq.push_back({1'b0, ws_char()});
      else if (t < 8) seq.push_back({1'b0, 8'($urandom)});
      else seq.push_back({1'b1, 8'($urandom)});
    end
    foreach (seq[i]) send_byte(seq[i][7:0], seq[i][8]);
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random stalls, plus long holds on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end else if (stall_left == 0 && out_idle_en && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: each transfer against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    itp_res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result value %0d status %0d pushback %0d saturated %0d",
                 $realtime, res_ch.value, res_ch.status, res_ch.pushback_count,
                 res_ch.saturated);
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        if (res_ch.value !== want.value) begin
          $display("%0t: value expected %0d actual %0d", $realtime,
                   $signed(want.value), res_ch.value);
          n_errors++;
        end
        if (res_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime,
                   want.status, res_ch.status);
          n_errors++;
        end
        if (res_ch.pushback_count !== want.pushback) begin
          $display("%0t: pushback_count expected %0d actual %0d", $realtime,
                   want.pushback, res_ch.pushback_count);
          n_errors++;
        end
        if (res_ch.saturated !== want.saturated) begin
          $display("%0t: saturated expected %0d actual %0d", $realtime,
                   want.saturated, res_ch.saturated);
          n_errors++;
        end
        case (want.status)
          ST_OK:   n_ok++;
          ST_NAN:  n_nan++;
          default: n_zero++;
        endcase
        if (want.saturated) n_sat++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Auto mode: whitespace kinds, signs, every prefix and their failure cases
  task automatic test_auto_prefixes();
    configure(BASE_AUTO, 11'd0);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_text(" -12 +7,0x1fA;0B101 017 09z");
    send_text("0");
    send_end();                          // lone zero at end of input
    send_text("0xg?+;-");                // bare prefix, bad byte, signs alone
    send_end();
    send_end();                          // end before any token
  endtask

  // Fixed bases: required prefixes, mismatches, end inside prefix, bad mode
  task automatic test_fixed_modes();
    configure(BASE_2, 11'd0);
    send_text("0b11 10c");
    configure(BASE_8, 11'd0);
    send_text("0777 ");
    configure(BASE_16, 11'd0);
    send_text("0XfF.0");
    send_end();
    configure(BASE_10, 11'd0);
    send_text("-5 0x");
    configure(5'd31, 11'd0);
    send_text("7 ");
  endtask

  // Clamping at both ends of the signed range
  task automatic test_saturation();
    configure(BASE_AUTO, 11'd0);
    send_text("18446744073709551616 -9223372036854775809 9223372036854775807 ");
    send_text("-9223372036854775808 0xFFFFFFFFFFFFFFFF ");
  endtask

  // Digit limits: one digit, a short limit, and the register maximum
  task automatic test_digit_limits();
    configure(BASE_AUTO, 11'd1);
    send_text("0z123 ");
    configure(BASE_AUTO, 11'd3);
    send_text("123456 -0x12 07777 098 ");
    configure(BASE_AUTO, 11'h7FF);
    send_text("0b");
    repeat (70) send_byte(CH_0 + 8'd1, 1'b0);
    send_byte(CH_SPACE, 1'b0);
  endtask

  // Long output stall while bytes keep coming, so the input must back up;
  // then the sender waits for every result before going on.
  task automatic test_output_backpressure();
    configure(BASE_AUTO, 11'd0);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    hold_req    = 300;
    repeat (25) send_random_token();
    settle_parser();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  // Random token streams across many register settings and idling patterns
  task automatic test_random_streams();
    logic [BASE_W-1:0] base;
    logic [CNT_W-1:0]  maxd;
    int start;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0, 1, 2, 8: base = BASE_AUTO;
        3, 11:      base = BASE_2;
        4:          base = BASE_8;
        5, 10:      base = BASE_10;
        6, 9:       base = BASE_16;
        default: begin
          do base = 5'($urandom);
          while (base == BASE_AUTO || base == BASE_2 || base == BASE_8 ||
                 base == BASE_10 || base == BASE_16);
        end
      endcase
      case (ph)
        0, 3, 6:  maxd = 11'd0;
        1, 9, 10: maxd = 11'd1;
        5, 8:     maxd = 11'h7FF;
        default:  maxd = 11'($urandom_range(2, 20));
      endcase
      configure(base, maxd);
      in_idle_en  = (ph % 4 == 0) || (ph % 4 == 1);
      out_idle_en = (ph % 4 == 0) || (ph % 4 == 2);
      start = n_bytes;
      while (n_bytes - start < 60) send_random_token();
    end
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_BASE_MODE;
    cfg_wdata_i          = '0;
    char_ch.valid        = 1'b0;
    char_ch.char_byte    = '0;
    char_ch.end_of_input = 1'b0;
    in_idle_en           = 1'b1;
    out_idle_en          = 1'b1;
    hold_req             = 0;
    n_errors             = 0;
    n_bytes              = 0;
    n_ok = 0; n_nan = 0; n_zero = 0; n_sat = 0;
    n_cfg_writes         = 0;
    cur_base_mode        = BASE_AUTO;
    cur_max_digits       = '0;
    clear_token();

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_auto_prefixes();
    test_fixed_modes();
    test_saturation();
    test_digit_limits();
    test_output_backpressure();
    test_random_streams();

    settle_parser();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes under %0d register writes; checked %0d numbers, %0d invalid,",
             n_bytes, n_cfg_writes, n_ok, n_nan);
    $display("%0d empty tokens and %0d clamped values", n_zero, n_sat);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: reports a timeout and stops the run
  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d results still pending", $realtime, expected_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/itp_pkg.sv
rtl/itp_if.sv
rtl/itp_front.sv
rtl/itp_queue.sv
rtl/itp_back.sv
rtl/integer_text_parser_auto_base.sv
rtl/itp_checker.sv
test/integer_text_parser_auto_base_tb.sv
